@@ sv/assert_macros.svh @@
// assertion macros for the filter top level
// expects signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/atmf_pkg.sv @@
// types, constants and widths for the trimmed mean filter
// no dependencies; used by every module of the block
package atmf_pkg;

  localparam int SAMPLE_COUNT = 64;
  localparam int TRIM_COUNT   = 4;
  localparam int WARMUP_COUNT = 2;
  localparam int SAMPLE_BITS  = 12;

  localparam int TRIM_EFF   = (2 * TRIM_COUNT >= SAMPLE_COUNT) ? (SAMPLE_COUNT - 1) / 2
                                                                : TRIM_COUNT;
  localparam int LO_IDX     = TRIM_EFF;
  localparam int HI_IDX     = SAMPLE_COUNT - TRIM_EFF;
  localparam int KEEP_COUNT = HI_IDX - LO_IDX;

  localparam int RAW_W  = 12;
  localparam int MV_W   = 13;
  localparam int STAT_W = 2;
  localparam int IDX_W  = $clog2(SAMPLE_COUNT);
  localparam int POS_W  = $clog2(WARMUP_COUNT + SAMPLE_COUNT + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLE_COUNT);
  localparam int DIVD_W = SAMPLE_BITS + MV_W;

  // mean: sum * ceil(2^s / keep) >> s is exact for every sum below 2^SUM_W
  localparam int AVG_SHIFT   = SUM_W + $clog2(KEEP_COUNT);
  localparam int AVG_RECIP_W = SUM_W + 1;
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
    ((64'd1 << AVG_SHIFT) + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT));

  // millivolts: the same reciprocal trick for the full scale code
  localparam int MASK_VAL   = (1 << SAMPLE_BITS) - 1;
  localparam int MV_SHIFT   = DIVD_W + $clog2(MASK_VAL);
  localparam int MV_RECIP_W = DIVD_W + 1;
  localparam int MV_PROD_W  = DIVD_W + MV_RECIP_W;
  localparam logic [MV_RECIP_W-1:0] MV_RECIP = MV_RECIP_W'(
    ((64'd1 << MV_SHIFT) + 64'(MASK_VAL) - 64'd1) / 64'(MASK_VAL));

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic REG_MAX_VALID  = 1'b1;
  localparam logic [MV_W-1:0] FULL_SCALE_RST = MV_W'(3100);
  localparam logic [MV_W-1:0] MAX_VALID_RST  = MV_W'(3300);

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FAIL  = 2'd2;

  typedef struct packed {
    logic [RAW_W-1:0] sample;
    logic             read_failed;
  } in_req_t;

  typedef struct packed {
    logic [RAW_W-1:0]  avg_raw;
    logic [MV_W-1:0]   millivolts;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_SCALE_GO,
    ST_SCALE_WAIT
  } state_t;

endpackage

@@ sv/atmf_cell.sv @@
// one slot of the insertion sort chain
// depends on atmf_pkg; shifts up on insert, down on drain
module atmf_cell (
  input  logic                             clk,
  input  atmf_pkg::cell_ctrl_t             ctrl,
  input  logic [atmf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [atmf_pkg::SAMPLE_BITS-1:0] prev_val,
  input  logic                             prev_gt,
  input  logic [atmf_pkg::SAMPLE_BITS-1:0] next_val,
  input  logic                             occupied,
  output logic [atmf_pkg::SAMPLE_BITS-1:0] val,
  output logic                             gt
);
  import atmf_pkg::*;

  logic                   take_new;
  logic [SAMPLE_BITS-1:0] val_next;

  // an empty slot counts as larger than anything
  assign gt       = occupied && (val > sample);
  assign take_new = !occupied || (val > sample);

  always_comb begin
    val_next = val;
    if (ctrl.insert) begin
      if (prev_gt) begin
        val_next = prev_val;
      end else if (take_new) begin
        val_next = sample;
      end
    end else if (ctrl.drain) begin
      val_next = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ sv/atmf_div.sv @@
// mean and millivolt scaling by reciprocal multiplication, three pipeline steps
// depends on atmf_pkg; started once per measurement by the top level
module atmf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [atmf_pkg::SUM_W-1:0] sum,
  input  logic [atmf_pkg::MV_W-1:0]  full_scale_mv,
  output logic                       done,
  output logic [atmf_pkg::RAW_W-1:0] avg,
  output logic [atmf_pkg::MV_W-1:0]  mv
);
  import atmf_pkg::*;

  logic                  mul_go;
  logic                  mv_go;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [DIVD_W-1:0]     product;
  logic [MV_PROD_W-1:0]  mv_prod;

  assign avg_prod = AVG_PROD_W'(sum) * AVG_PROD_W'(AVG_RECIP);
  assign mv_prod  = MV_PROD_W'(product) * MV_PROD_W'(MV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go <= 1'b0;
      mv_go  <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_go <= start;
      mv_go  <= mul_go;
      done   <= mv_go;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      avg <= avg_prod[AVG_SHIFT +: RAW_W];
    end
    if (mul_go) begin
      product <= DIVD_W'(avg) * DIVD_W'(full_scale_mv);
    end
    if (mv_go) begin
      mv <= mv_prod[MV_SHIFT +: MV_W];
    end
  end

endmodule

@@ sv/adc_trimmed_mean_filter_top.sv @@
// top level of the trimmed mean filter: request control, sort chain, apb registers
// depends on atmf_pkg, atmf_cell, atmf_div and assert_macros.svh
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------
//  request  | start, busy (taken: start&!busy) | req (sample, read_failed)
//  result   | done, one cycle, no back-press  | result (avg_raw, millivolts, status)
//  config   | apb psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// warmup and collection requests are accepted back to back while busy is low;
// a failed read gives its result in the cycle after it is taken.
// the last sample of a measurement starts a drain of the cell chain into the
// accumulator, then a state that launches the scaling, then the mean, multiply
// and millivolt steps, all with busy high, and the result strobe comes in the
// first cycle with busy low. the receiver cannot stall.
// rst is synchronous, clears the position and the state and resets the registers to their defaults.
module adc_trimmed_mean_filter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  atmf_pkg::in_req_t             req,
  output logic                          done,
  output atmf_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [atmf_pkg::DATA_W-1:0]   pwdata,
  output logic [atmf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import atmf_pkg::*;
`include "assert_macros.svh"

  state_t state, state_next;

  logic [MV_W-1:0]   full_scale_mv;
  logic [MV_W-1:0]   max_valid_mv;
  logic [POS_W-1:0]  position;
  logic [IDX_W-1:0]  drain_idx;
  logic [SUM_W-1:0]  acc;

  logic              take;
  logic              insert;
  logic              last_item;
  logic              reg_idx;
  cell_ctrl_t        ctrl;

  logic [SAMPLE_BITS-1:0] cell_val [SAMPLE_COUNT];
  logic                   cell_gt  [SAMPLE_COUNT];
  logic [SAMPLE_BITS-1:0] new_sample;

  logic              div_start;
  logic              div_done;
  logic [RAW_W-1:0]  div_avg;
  logic [MV_W-1:0]   div_mv;

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1];

  always_comb begin
    unique case (reg_idx)
      REG_FULL_SCALE: prdata = DATA_W'(full_scale_mv);
      REG_MAX_VALID:  prdata = DATA_W'(max_valid_mv);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv <= FULL_SCALE_RST;
      max_valid_mv  <= MAX_VALID_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_idx == REG_FULL_SCALE) full_scale_mv <= pwdata[MV_W-1:0];
      if (reg_idx == REG_MAX_VALID)  max_valid_mv  <= pwdata[MV_W-1:0];
    end
  end

  // ---------------- request control
  assign busy       = (state != ST_COLLECT);
  assign take       = start && !busy;
  assign new_sample = req.sample[SAMPLE_BITS-1:0];
  assign insert     = take && !req.read_failed && (int'(position) >= WARMUP_COUNT);
  assign last_item  = insert && (int'(position) == WARMUP_COUNT + SAMPLE_COUNT - 1);
  assign ctrl       = '{insert: insert, drain: (state == ST_DRAIN)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_COLLECT:    if (last_item) state_next = ST_DRAIN;
      ST_DRAIN:      if (drain_idx == IDX_W'(SAMPLE_COUNT - 1)) state_next = ST_SCALE_GO;
      ST_SCALE_GO: begin
        div_start  = 1'b1;
        state_next = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: if (div_done) state_next = ST_COLLECT;
      default:       state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take) begin
      if (req.read_failed || last_item) begin
        position <= '0;
      end else begin
        position <= position + 1'b1;
      end
    end
  end

  // ---------------- sort chain
  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    logic                   occ;
    logic [SAMPLE_BITS-1:0] pv;
    logic                   pg;
    logic [SAMPLE_BITS-1:0] nv;

    assign occ = (int'(position) > WARMUP_COUNT + i);
    if (i == 0) begin : g_head
      assign pv = new_sample;
      assign pg = 1'b0;
    end else begin : g_body
      assign pv = cell_val[i-1];
      assign pg = cell_gt[i-1];
    end
    if (i == SAMPLE_COUNT - 1) begin : g_tail
      assign nv = cell_val[i];
    end else begin : g_inner
      assign nv = cell_val[i+1];
    end

    atmf_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sample   (new_sample),
      .prev_val (pv),
      .prev_gt  (pg),
      .next_val (nv),
      .occupied (occ),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  // drain walks the sorted values out of the head cell, lowest first
  always_ff @(posedge clk) begin
    if (last_item) begin
      drain_idx <= '0;
      acc       <= '0;
    end else if (state == ST_DRAIN) begin
      drain_idx <= drain_idx + 1'b1;
      if (int'(drain_idx) >= LO_IDX && int'(drain_idx) < HI_IDX) begin
        acc <= acc + SUM_W'(cell_val[0]);
      end
    end
  end

  // ---------------- mean and scaling
  atmf_div u_div (
    .clk           (clk),
    .rst           (rst),
    .start         (div_start),
    .sum           (acc),
    .full_scale_mv (full_scale_mv),
    .done          (div_done),
    .avg           (div_avg),
    .mv            (div_mv)
  );

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (take && req.read_failed) || (state == ST_SCALE_WAIT && div_done);
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.read_failed) begin
      result <= '{avg_raw: '0, millivolts: '0, status: STATUS_FAIL};
    end else if (state == ST_SCALE_WAIT && div_done) begin
      result <= '{avg_raw: div_avg, millivolts: div_mv,
                  status: (div_mv > max_valid_mv) ? STATUS_RANGE : STATUS_OK};
    end
  end

  `ASSERT_NEXT(ast_fail_result, take && req.read_failed,
               done && result.status == STATUS_FAIL, "failed read did not report")
  `ASSERT_HOLDS(ast_pos_bound,
                int'(position) <= WARMUP_COUNT + SAMPLE_COUNT - 1, "position overran")
  `ASSERT_SAME(ast_done_idle, done, state == ST_COLLECT, "result while still computing")
  `ASSERT_SAME(ast_ok_in_range, done && result.status == STATUS_OK,
               result.millivolts <= max_valid_mv, "ok status above limit")

endmodule
